// File: hdl/i2cbs_pkg.sv
package i2cbs_pkg;

    typedef enum logic [2:0] {
        CMD_TICK  = 3'd0,
        CMD_START = 3'd1,
        CMD_STOP  = 3'd2,
        CMD_WRITE = 3'd3,
        CMD_READ  = 3'd4
    } cmd_t;

    typedef enum logic [2:0] {
        OP_IDLE  = 3'd0,
        OP_START = 3'd1,
        OP_STOP  = 3'd2,
        OP_WRITE = 3'd3,
        OP_READ  = 3'd4
    } op_t;

    typedef enum logic {
        REG_WRITE_WAIT = 1'b0,
        REG_READ_WAIT  = 1'b1
    } reg_index_t;

    localparam logic [15:0] WRITE_WAIT_RESET = 16'd1000;
    localparam logic [15:0] READ_WAIT_RESET  = 16'd5;
    localparam logic [3:0]  BITS_PER_BYTE    = 4'd8;

    typedef struct packed {
        op_t         op;
        logic [3:0]  phase;
        logic [3:0]  bit_index;
        logic [7:0]  shift_byte;
        logic [15:0] wait_count;
        logic        scl;
        logic        sda;
        logic        ack_choice;
        logic [7:0]  last_read;
    } seq_state_t;

    localparam seq_state_t SEQ_STATE_RESET = '{
        op:         OP_IDLE,
        phase:      4'd0,
        bit_index:  4'd0,
        shift_byte: 8'd0,
        wait_count: 16'd0,
        scl:        1'b1,
        sda:        1'b1,
        ack_choice: 1'b0,
        last_read:  8'd0
    };

    typedef struct packed {
        logic        rejected;
        logic [7:0]  read_data;
        logic        done_res;
        logic        busy_res;
        logic        sda_level;
        logic        scl_level;
    } result_t;

endpackage

// File: hdl/i2cbs_step.sv
module i2cbs_step
(
    input  i2cbs_pkg::seq_state_t cur,
    input  logic [2:0]            command,
    input  logic [7:0]            write_data,
    input  logic                  read_nack,
    input  logic                  sda_in,
    input  logic [15:0]           write_wait_ticks,
    input  logic [15:0]           read_wait_ticks,
    output i2cbs_pkg::seq_state_t nxt,
    output i2cbs_pkg::result_t    result
);

    logic        run;
    logic        sample;
    logic        seg_end;
    logic        is_cmd;
    logic [15:0] wait_len;

    always_comb
    begin
        nxt      = cur;
        run      = 1'b0;
        sample   = 1'b0;
        seg_end  = 1'b0;
        is_cmd   = 1'b0;
        wait_len = 16'd0;
        result   = '0;

        case (i2cbs_pkg::cmd_t'(command))
            i2cbs_pkg::CMD_START: is_cmd = 1'b1;
            i2cbs_pkg::CMD_STOP:  is_cmd = 1'b1;
            i2cbs_pkg::CMD_WRITE: is_cmd = 1'b1;
            i2cbs_pkg::CMD_READ:  is_cmd = 1'b1;
            default:              is_cmd = 1'b0;
        endcase

        if (is_cmd)
        begin
            if (cur.op != i2cbs_pkg::OP_IDLE)
            begin
                result.rejected = 1'b1;
            end
            else
            begin
                nxt.op         = i2cbs_pkg::op_t'(command);
                nxt.phase      = 4'd0;
                nxt.bit_index  = 4'd0;
                nxt.shift_byte = (command == i2cbs_pkg::CMD_WRITE) ? write_data : 8'd0;
                nxt.ack_choice = read_nack;
                if (command == i2cbs_pkg::CMD_READ)
                begin
                    nxt.sda = 1'b1;
                end
                run = 1'b1;
            end
        end
        else if (cur.op != i2cbs_pkg::OP_IDLE)
        begin
            if (cur.wait_count > 16'd1)
            begin
                nxt.wait_count = cur.wait_count - 16'd1;
            end
            else
            begin
                run    = 1'b1;
                sample = sda_in;
            end
        end

        if (run)
        begin
            case (nxt.op)
                i2cbs_pkg::OP_START:
                begin
                    case (nxt.phase)
                        4'd0:
                        begin
                            nxt.sda = 1'b1;
                            nxt.scl = 1'b1;
                        end
                        4'd1:    nxt.sda = 1'b0;
                        4'd2:    nxt.scl = 1'b0;
                        default: seg_end = 1'b1;
                    endcase
                    nxt.phase = nxt.phase + 4'd1;
                end
                i2cbs_pkg::OP_STOP:
                begin
                    case (nxt.phase)
                        4'd0:
                        begin
                            nxt.scl = 1'b0;
                            nxt.sda = 1'b0;
                        end
                        4'd1:    nxt.scl = 1'b1;
                        4'd2:    nxt.sda = 1'b1;
                        default: seg_end = 1'b1;
                    endcase
                    nxt.phase = nxt.phase + 4'd1;
                end
                i2cbs_pkg::OP_WRITE:
                begin
                    if (nxt.bit_index < i2cbs_pkg::BITS_PER_BYTE)
                    begin
                        case (nxt.phase)
                            4'd0: nxt.scl = 1'b0;
                            4'd1:
                            begin
                                nxt.sda        = nxt.shift_byte[7];
                                nxt.shift_byte = {nxt.shift_byte[6:0], 1'b0};
                            end
                            default: nxt.scl = 1'b1;
                        endcase
                        nxt.phase = nxt.phase + 4'd1;
                        if (nxt.phase >= 4'd3)
                        begin
                            nxt.phase     = 4'd0;
                            nxt.bit_index = nxt.bit_index + 4'd1;
                        end
                    end
                    else
                    begin
                        // ack clock: driven, not sampled
                        case (nxt.phase)
                            4'd0:
                            begin
                                nxt.scl = 1'b0;
                                nxt.sda = 1'b1;
                            end
                            4'd1: nxt.scl = 1'b1;
                            default:
                            begin
                                nxt.scl = 1'b0;
                                seg_end = 1'b1;
                            end
                        endcase
                        nxt.phase = nxt.phase + 4'd1;
                    end
                end
                i2cbs_pkg::OP_READ:
                begin
                    if (nxt.bit_index < i2cbs_pkg::BITS_PER_BYTE)
                    begin
                        case (nxt.phase)
                            4'd0:    nxt.scl = 1'b0;
                            4'd1:    nxt.scl = 1'b1;
                            default: nxt.shift_byte = {nxt.shift_byte[6:0], sample};
                        endcase
                        nxt.phase = nxt.phase + 4'd1;
                        if (nxt.phase >= 4'd3)
                        begin
                            nxt.phase     = 4'd0;
                            nxt.bit_index = nxt.bit_index + 4'd1;
                        end
                    end
                    else
                    begin
                        case (nxt.phase)
                            4'd0:
                            begin
                                nxt.scl = 1'b0;
                                nxt.sda = nxt.ack_choice;
                            end
                            4'd1: nxt.scl = 1'b1;
                            4'd2:
                            begin
                                nxt.scl = 1'b0;
                                nxt.sda = 1'b1;
                            end
                            default:
                            begin
                                nxt.last_read = nxt.shift_byte;
                                seg_end       = 1'b1;
                            end
                        endcase
                        nxt.phase = nxt.phase + 4'd1;
                    end
                end
                default: seg_end = 1'b1;
            endcase

            if (seg_end)
            begin
                nxt.op          = i2cbs_pkg::OP_IDLE;
                nxt.phase       = 4'd0;
                nxt.bit_index   = 4'd0;
                nxt.wait_count  = 16'd0;
                result.done_res = 1'b1;
            end
            else
            begin
                wait_len = (nxt.op == i2cbs_pkg::OP_READ) ? read_wait_ticks
                                                          : write_wait_ticks;
                nxt.wait_count = (wait_len == 16'd0) ? 16'd1 : wait_len;
            end
        end

        result.scl_level = nxt.scl;
        result.sda_level = nxt.sda;
        result.busy_res  = (nxt.op != i2cbs_pkg::OP_IDLE);
        result.read_data = nxt.last_read;
    end

endmodule

// File: hdl/i2c_master_bit_sequencer.sv
// Channel   Dir  Accept               Contents
// s_*       in   s_tvalid & s_tready  tuser: command; tdata: write_data, read_nack, sda_in
// m_*       out  m_tvalid & m_tready  tdata: scl, sda, busy, done, read_data, rejected
// cfg_*     in   cfg_we               index 0 write wait, 1 read wait
//
// One request per clock; its result sits in the output register the next cycle.
// s_tready is high when the output register is empty or being drained.
// A stalled m_tready holds the result and blocks further requests.
// rst_n clears the sequencer to idle with both lines released.
module i2c_master_bit_sequencer
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] write_data, [8] read_nack, [9] sda_in
    input  logic [2:0]  s_tuser,   // [2:0] command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [0] scl_level, [1] sda_level, [2] busy_res,
                                   // [3] done_res, [11:4] read_data, [12] rejected
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);

    i2cbs_pkg::seq_state_t state_reg;
    i2cbs_pkg::seq_state_t state_next;
    i2cbs_pkg::result_t    res_next;
    i2cbs_pkg::result_t    res_reg;
    logic                  valid_reg;
    logic [15:0]           write_wait_reg;
    logic [15:0]           read_wait_reg;
    logic                  accept;

    assign s_tready = !valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    i2cbs_step u_step
    (
        .cur              (state_reg),
        .command          (s_tuser),
        .write_data       (s_tdata[7:0]),
        .read_nack        (s_tdata[8]),
        .sda_in           (s_tdata[9]),
        .write_wait_ticks (write_wait_reg),
        .read_wait_ticks  (read_wait_reg),
        .nxt              (state_next),
        .result           (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            write_wait_reg <= i2cbs_pkg::WRITE_WAIT_RESET;
            read_wait_reg  <= i2cbs_pkg::READ_WAIT_RESET;
        end
        else if (cfg_we)
        begin
            case (i2cbs_pkg::reg_index_t'(cfg_index))
                i2cbs_pkg::REG_WRITE_WAIT: write_wait_reg <= cfg_data;
                i2cbs_pkg::REG_READ_WAIT:  read_wait_reg  <= cfg_data;
                default:                   write_wait_reg <= write_wait_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= i2cbs_pkg::SEQ_STATE_RESET;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                state_reg <= state_next;
                valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_reg <= res_next;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {3'd0, res_reg.rejected, res_reg.read_data, res_reg.done_res,
                       res_reg.busy_res, res_reg.sda_level, res_reg.scl_level};

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int TIMEOUT_CYCLES = 3_000_000;
    localparam int RANDOM_ITEMS   = 600;

    localparam int SDA_LOW    = 0;
    localparam int SDA_HIGH   = 1;
    localparam int SDA_RANDOM = 2;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata   = '0;   // [7:0] write_data, [8] read_nack, [9] sda_in
    logic [2:0]  s_tuser   = '0;   // [2:0] command
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [15:0] m_tdata;          // [0] scl, [1] sda, [2] busy, [3] done,
                                   // [11:4] read_data, [12] rejected
    logic        cfg_we    = 1'b0;
    logic        cfg_index = 1'b0;
    logic [15:0] cfg_data  = '0;

    // bus model state
    i2cbs_pkg::op_t bus_op;
    logic [3:0]     bus_phase;
    logic [3:0]     bus_bit;
    logic [7:0]     bus_shift;
    logic [15:0]    bus_wait;
    logic           bus_scl;
    logic           bus_sda;
    logic           bus_ack;
    logic [7:0]     bus_last_read;
    logic [15:0]    write_wait_reg;
    logic [15:0]    read_wait_reg;

    i2cbs_pkg::result_t expected_pins_q[$];

    int          fail_count    = 0;
    int          request_count = 0;
    int          cycle_count   = 0;
    int          stall_left    = 0;
    bit          src_idle_on   = 1'b1;
    bit          sink_stall_on = 1'b1;

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    i2c_master_bit_sequencer u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // one pin-sequence segment; returns 1 when the command completes
    function automatic logic advance_segment(input logic sda_sample);
        logic        last_seg;
        logic [15:0] w;
        last_seg = 1'b0;
        case (bus_op)
            i2cbs_pkg::OP_START:
            begin
                if (bus_phase == 4'd0)
                begin
                    bus_sda = 1'b1;
                    bus_scl = 1'b1;
                end
                else if (bus_phase == 4'd1)
                    bus_sda = 1'b0;
                else if (bus_phase == 4'd2)
                    bus_scl = 1'b0;
                else
                    last_seg = 1'b1;
                bus_phase++;
            end
            i2cbs_pkg::OP_STOP:
            begin
                if (bus_phase == 4'd0)
                begin
                    bus_scl = 1'b0;
                    bus_sda = 1'b0;
                end
                else if (bus_phase == 4'd1)
                    bus_scl = 1'b1;
                else if (bus_phase == 4'd2)
                    bus_sda = 1'b1;
                else
                    last_seg = 1'b1;
                bus_phase++;
            end
            i2cbs_pkg::OP_WRITE:
            begin
                if (bus_bit < i2cbs_pkg::BITS_PER_BYTE)
                begin
                    if (bus_phase == 4'd0)
                        bus_scl = 1'b0;
                    else if (bus_phase == 4'd1)
                    begin
                        bus_sda   = bus_shift[7];
                        bus_shift = {bus_shift[6:0], 1'b0};
                    end
                    else
                        bus_scl = 1'b1;
                    bus_phase++;
                    if (bus_phase >= 4'd3)
                    begin
                        bus_phase = 4'd0;
                        bus_bit++;
                    end
                end
                else
                begin
                    // ack clock, slave ack not sampled
                    if (bus_phase == 4'd0)
                    begin
                        bus_scl = 1'b0;
                        bus_sda = 1'b1;
                    end
                    else if (bus_phase == 4'd1)
                        bus_scl = 1'b1;
                    else
                    begin
                        bus_scl  = 1'b0;
                        last_seg = 1'b1;
                    end
                    bus_phase++;
                end
            end
            i2cbs_pkg::OP_READ:
            begin
                if (bus_bit < i2cbs_pkg::BITS_PER_BYTE)
                begin
                    if (bus_phase == 4'd0)
                        bus_scl = 1'b0;
                    else if (bus_phase == 4'd1)
                        bus_scl = 1'b1;
                    else
                        bus_shift = {bus_shift[6:0], sda_sample};
                    bus_phase++;
                    if (bus_phase >= 4'd3)
                    begin
                        bus_phase = 4'd0;
                        bus_bit++;
                    end
                end
                else
                begin
                    if (bus_phase == 4'd0)
                    begin
                        bus_scl = 1'b0;
                        bus_sda = bus_ack;
                    end
                    else if (bus_phase == 4'd1)
                        bus_scl = 1'b1;
                    else if (bus_phase == 4'd2)
                    begin
                        bus_scl = 1'b0;
                        bus_sda = 1'b1;
                    end
                    else
                    begin
                        bus_last_read = bus_shift;
                        last_seg      = 1'b1;
                    end
                    bus_phase++;
                end
            end
            default:
                last_seg = 1'b1;
        endcase
        if (last_seg)
        begin
            bus_op    = i2cbs_pkg::OP_IDLE;
            bus_phase = 4'd0;
            bus_bit   = 4'd0;
            bus_wait  = 16'd0;
        end
        else
        begin
            w        = (bus_op == i2cbs_pkg::OP_READ) ? read_wait_reg : write_wait_reg;
            bus_wait = (w == 16'd0) ? 16'd1 : w;
        end
        return last_seg;
    endfunction

    function automatic i2cbs_pkg::result_t predict_bus_step(input logic [2:0] cmd,
                                                            input logic [7:0] data,
                                                            input logic nack,
                                                            input logic sda);
        i2cbs_pkg::result_t r;
        logic               done;
        logic               rej;
        done = 1'b0;
        rej  = 1'b0;
        if (cmd == i2cbs_pkg::CMD_START || cmd == i2cbs_pkg::CMD_STOP ||
            cmd == i2cbs_pkg::CMD_WRITE || cmd == i2cbs_pkg::CMD_READ)
        begin
            if (bus_op != i2cbs_pkg::OP_IDLE)
                rej = 1'b1;
            else
            begin
                bus_op    = i2cbs_pkg::op_t'(cmd);
                bus_phase = 4'd0;
                bus_bit   = 4'd0;
                bus_shift = (cmd == i2cbs_pkg::CMD_WRITE) ? data : 8'd0;
                bus_ack   = nack;
                if (cmd == i2cbs_pkg::CMD_READ)
                    bus_sda = 1'b1;
                done = advance_segment(1'b0);
            end
        end
        else if (bus_op != i2cbs_pkg::OP_IDLE)
        begin
            // tick, undefined codes count as tick
            if (bus_wait > 16'd1)
                bus_wait--;
            else
                done = advance_segment(sda);
        end
        r.scl_level = bus_scl;
        r.sda_level = bus_sda;
        r.busy_res  = (bus_op != i2cbs_pkg::OP_IDLE);
        r.done_res  = done;
        r.read_data = bus_last_read;
        r.rejected  = rej;
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        if (!src_idle_on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    function automatic logic pick_sda(input int mode);
        if (mode == SDA_LOW)
            return 1'b0;
        if (mode == SDA_HIGH)
            return 1'b1;
        return 1'($urandom_range(0, 1));
    endfunction

    function automatic logic [15:0] pick_wait();
        if ($urandom_range(0, 9) == 0)
            return 16'd0;
        return 16'($urandom_range(1, 3));
    endfunction

    task automatic send_request(input logic [2:0] cmd, input logic [7:0] data,
                                input logic nack, input logic sda);
        int gap;
        gap = pick_gap();
        repeat (gap)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {6'b0, sda, nack, data};
        do
            @(posedge clk);
        while (!s_tready);
        expected_pins_q.push_back(predict_bus_step(cmd, data, nack, sda));
        request_count++;
    endtask

    // ticks until the sequence ends, with optional rejected commands and odd codes mixed in
    task automatic tick_until_idle(input int sda_mode, input int reject_pct, input int odd_pct);
        logic [2:0] cmd;
        while (bus_op != i2cbs_pkg::OP_IDLE)
        begin
            if ($urandom_range(0, 99) < reject_pct)
                cmd = 3'($urandom_range(i2cbs_pkg::CMD_START, i2cbs_pkg::CMD_READ));
            else if ($urandom_range(0, 99) < odd_pct)
                cmd = 3'($urandom_range(5, 7));
            else
                cmd = i2cbs_pkg::CMD_TICK;
            send_request(cmd, 8'($urandom), 1'($urandom), pick_sda(sda_mode));
        end
    endtask

    task automatic run_command(input logic [2:0] cmd, input logic [7:0] data,
                               input logic nack, input int sda_mode);
        send_request(cmd, data, nack, 1'($urandom));
        tick_until_idle(sda_mode, 0, 0);
    endtask

    task automatic drain_results();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (expected_pins_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_register(input i2cbs_pkg::reg_index_t idx, input logic [15:0] value);
        drain_results();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        if (idx == i2cbs_pkg::REG_WRITE_WAIT)
            write_wait_reg = value;
        else
            read_wait_reg = value;
    endtask

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk)
    begin : check_results
        i2cbs_pkg::result_t got;
        i2cbs_pkg::result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = i2cbs_pkg::result_t'(m_tdata[12:0]);
            if (expected_pins_q.size() == 0)
            begin
                $error("result with no request pending: %h", m_tdata);
                fail_count++;
            end
            else
            begin
                want = expected_pins_q.pop_front();
                check_field("scl_level", want.scl_level, got.scl_level);
                check_field("sda_level", want.sda_level, got.sda_level);
                check_field("busy_res",  want.busy_res,  got.busy_res);
                check_field("done_res",  want.done_res,  got.done_res);
                check_field("read_data", want.read_data, got.read_data);
                check_field("rejected",  want.rejected,  got.rejected);
            end
        end
    end

    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            m_tready <= 1'b0;
            stall_left--;
        end
        else if (sink_stall_on && $urandom_range(0, 7) == 0)
        begin
            m_tready   <= 1'b0;
            stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
                                                     : $urandom_range(0, 2);
        end
        else
            m_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > TIMEOUT_CYCLES)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic test_idle_ticks();
        send_request(i2cbs_pkg::CMD_TICK, 8'h00, 1'b0, 1'b0);
        send_request(i2cbs_pkg::CMD_TICK, 8'hFF, 1'b1, 1'b1);
        send_request(3'd5, 8'h5A, 1'b0, 1'b1);
        send_request(3'd6, 8'hA5, 1'b1, 1'b0);
        send_request(3'd7, 8'h3C, 1'b1, 1'b1);
    endtask

    task automatic test_directed_commands();
        write_register(i2cbs_pkg::REG_WRITE_WAIT, 16'd1);
        write_register(i2cbs_pkg::REG_READ_WAIT, 16'd1);
        run_command(i2cbs_pkg::CMD_START, 8'h00, 1'b0, SDA_RANDOM);
        run_command(i2cbs_pkg::CMD_WRITE, 8'h00, 1'b0, SDA_RANDOM);
        run_command(i2cbs_pkg::CMD_WRITE, 8'hFF, 1'b1, SDA_RANDOM);
        run_command(i2cbs_pkg::CMD_WRITE, 8'hA5, 1'b0, SDA_RANDOM);
        run_command(i2cbs_pkg::CMD_READ, 8'h00, 1'b0, SDA_HIGH);
        run_command(i2cbs_pkg::CMD_READ, 8'hFF, 1'b1, SDA_LOW);
        run_command(i2cbs_pkg::CMD_READ, 8'h00, 1'b0, SDA_RANDOM);
        run_command(i2cbs_pkg::CMD_STOP, 8'h00, 1'b0, SDA_RANDOM);
    endtask

    task automatic test_busy_rejects();
        write_register(i2cbs_pkg::REG_WRITE_WAIT, 16'd2);
        write_register(i2cbs_pkg::REG_READ_WAIT, 16'd2);
        send_request(i2cbs_pkg::CMD_WRITE, 8'h96, 1'b0, 1'b0);
        send_request(i2cbs_pkg::CMD_START, 8'h00, 1'b0, 1'b0);
        send_request(i2cbs_pkg::CMD_STOP, 8'h00, 1'b0, 1'b1);
        send_request(i2cbs_pkg::CMD_WRITE, 8'hFF, 1'b1, 1'b0);
        send_request(i2cbs_pkg::CMD_READ, 8'h00, 1'b1, 1'b1);
        tick_until_idle(SDA_RANDOM, 20, 10);
        send_request(i2cbs_pkg::CMD_READ, 8'h00, 1'b1, 1'b0);
        tick_until_idle(SDA_RANDOM, 20, 10);
    endtask

    task automatic test_wait_extremes();
        // zero wait behaves as one tick
        write_register(i2cbs_pkg::REG_WRITE_WAIT, 16'd0);
        write_register(i2cbs_pkg::REG_READ_WAIT, 16'd0);
        run_command(i2cbs_pkg::CMD_START, 8'h00, 1'b0, SDA_RANDOM);
        run_command(i2cbs_pkg::CMD_READ, 8'h00, 1'b1, SDA_RANDOM);
        run_command(i2cbs_pkg::CMD_WRITE, 8'($urandom), 1'b0, SDA_RANDOM);
        run_command(i2cbs_pkg::CMD_STOP, 8'h00, 1'b0, SDA_RANDOM);
        // long write wait, read wait at full scale but unused by stop
        write_register(i2cbs_pkg::REG_READ_WAIT, 16'hFFFF);
        write_register(i2cbs_pkg::REG_WRITE_WAIT, 16'd200);
        src_idle_on   = 1'b0;
        sink_stall_on = 1'b0;
        run_command(i2cbs_pkg::CMD_STOP, 8'h00, 1'b0, SDA_RANDOM);
        src_idle_on   = 1'b1;
        sink_stall_on = 1'b1;
    endtask

    task automatic test_random_traffic();
        int         target;
        int         seq;
        logic [2:0] odd_cmd;
        target = request_count + RANDOM_ITEMS;
        seq    = 0;
        while (request_count < target)
        begin
            if (seq % 8 == 0)
            begin
                write_register(i2cbs_pkg::REG_WRITE_WAIT, pick_wait());
                write_register(i2cbs_pkg::REG_READ_WAIT, pick_wait());
            end
            src_idle_on   = ($urandom_range(0, 3) != 0);
            sink_stall_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 7) == 0)
            begin
                repeat ($urandom_range(1, 4))
                begin
                    odd_cmd = $urandom_range(0, 1) ? 3'(i2cbs_pkg::CMD_TICK)
                                                   : 3'($urandom_range(5, 7));
                    send_request(odd_cmd, 8'($urandom), 1'($urandom), 1'($urandom));
                end
            end
            else
            begin
                send_request(3'($urandom_range(i2cbs_pkg::CMD_START, i2cbs_pkg::CMD_READ)),
                             8'($urandom), 1'($urandom), 1'($urandom));
                tick_until_idle(SDA_RANDOM, 4, 6);
            end
            seq++;
        end
        src_idle_on   = 1'b1;
        sink_stall_on = 1'b1;
    endtask

    initial
    begin
        bus_op         = i2cbs_pkg::OP_IDLE;
        bus_phase      = 4'd0;
        bus_bit        = 4'd0;
        bus_shift      = 8'd0;
        bus_wait       = 16'd0;
        bus_scl        = 1'b1;
        bus_sda        = 1'b1;
        bus_ack        = 1'b0;
        bus_last_read  = 8'd0;
        write_wait_reg = i2cbs_pkg::WRITE_WAIT_RESET;
        read_wait_reg  = i2cbs_pkg::READ_WAIT_RESET;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        test_idle_ticks();
        test_directed_commands();
        test_busy_rejects();
        test_wait_extremes();
        test_random_traffic();

        drain_results();
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
